// ----- hw/rtl/trial_division_prime_test_assert.svh -----
// assertion macros for the checker of the trial division prime test
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// consequent must hold in the cycle after the antecedent, ignored while in reset
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed one cycle after trigger");

// consequent must hold in the same cycle as the antecedent, ignored while in reset
`define TDPT_ASSERT_SAME(label, clk, ante, cons, rst) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in the trigger cycle");

// next-cycle check that also runs while reset is asserted
`define TDPT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed one cycle after trigger, reset included");

`endif

// ----- hw/rtl/tdpt_pkg.sv -----
// shared constants and types of the trial division prime test
package tdpt_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int REQ_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = 8;
   localparam int STEP_CNT_WIDTH  = $clog2(DATA_WIDTH + 1);
   localparam int FIRST_DIVISOR   = 2;

   // handshake between the sequencer and the divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hw/rtl/tdpt_divider.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module tdpt_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  tdpt_pkg::div_ctrl_type              ctrl,
   input  logic [tdpt_pkg::DATA_WIDTH-1:0]     dividend,
   input  logic [tdpt_pkg::DATA_WIDTH-1:0]     divisor,
   output tdpt_pkg::div_status_type            status,
   output logic [tdpt_pkg::DATA_WIDTH-1:0]     quotient,
   output logic [tdpt_pkg::DATA_WIDTH-1:0]     remainder
);

   logic [tdpt_pkg::DATA_WIDTH-1:0]     rem_ff, rem_in;
   logic [tdpt_pkg::DATA_WIDTH-1:0]     quo_ff, quo_in;
   logic [tdpt_pkg::DATA_WIDTH-1:0]     div_ff, div_in;
   logic [tdpt_pkg::STEP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                                done_ff, done_in;
   logic [tdpt_pkg::DATA_WIDTH:0]       trial;
   logic [tdpt_pkg::DATA_WIDTH:0]       diff;
   logic                                fits;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[tdpt_pkg::DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = tdpt_pkg::STEP_CNT_WIDTH'(tdpt_pkg::DATA_WIDTH);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[tdpt_pkg::DATA_WIDTH-1:0] : trial[tdpt_pkg::DATA_WIDTH-1:0];
         quo_in  = {quo_ff[tdpt_pkg::DATA_WIDTH-2:0], fits};
         cnt_in  = cnt_ff - tdpt_pkg::STEP_CNT_WIDTH'(1);
         done_in = (cnt_ff == tdpt_pkg::STEP_CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// top level of the trial division prime test
//
//  channel  direction  beat content
//  req_     in         number, signed, tdata[31:0]
//  rsp_     out        is_prime_flag, tdata[0], tdata[7:1] zero
//
// a number below two goes straight to the verdict; otherwise each tried divisor
// takes a start step, 32 bit-serial divide steps and a decision, one divisor
// after another in the single shared divider, until a divisor exceeds the quotient
// (its square passes the number) or divides the number evenly
// req_tready is high only while no number is being tested; one result may
// wait in the output register while the next beat is taken
// reset is synchronous and clears the sequencer and the output valid
module trial_division_prime_test (
   input  logic                                     clock,
   input  logic                                     reset,
   // slave side: number [31:0]
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic signed [tdpt_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // master side: is_prime_flag [0], zero fill [7:1]
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [tdpt_pkg::RSP_TDATA_WIDTH-1:0]     rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [tdpt_pkg::DATA_WIDTH-1:0]  num_ff, num_in;    // number under test
   logic [tdpt_pkg::DATA_WIDTH-1:0]  dvr_ff, dvr_in;    // current trial divisor
   logic                             flag_ff, flag_in;  // verdict awaiting the output slot
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_flag_ff, rsp_flag_in;

   logic                             req_beat;
   logic                             slot_free;
   logic [tdpt_pkg::DATA_WIDTH-1:0]  req_num;
   tdpt_pkg::div_ctrl_type           div_ctrl;
   tdpt_pkg::div_status_type         div_status;
   logic [tdpt_pkg::DATA_WIDTH-1:0]  quotient;
   logic [tdpt_pkg::DATA_WIDTH-1:0]  remainder;

   assign req_num    = req_tdata[tdpt_pkg::DATA_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   // output register can take a result when empty or being drained
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // the divider is kicked for one cycle per trial divisor
   assign div_ctrl.start = (state_ff == ST_START);

   tdpt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (num_ff),
      .divisor   (dvr_ff),
      .status    (div_status),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      dvr_in       = dvr_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               num_in = req_num;
               dvr_in = tdpt_pkg::DATA_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
               // negative, zero and one are never prime
               if (req_num[tdpt_pkg::DATA_WIDTH-1] ||
                   req_num < tdpt_pkg::DATA_WIDTH'(tdpt_pkg::FIRST_DIVISOR)) begin
                  flag_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               // divisor past the quotient means divisor squared exceeds the number
               if (dvr_ff > quotient) begin
                  flag_in  = 1'b1;
                  state_in = ST_DONE;
               end else if (remainder == '0) begin
                  flag_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  dvr_in   = dvr_ff + tdpt_pkg::DATA_WIDTH'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      dvr_ff      <= dvr_in;
      flag_ff     <= flag_in;
      rsp_flag_ff <= rsp_flag_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(tdpt_pkg::RSP_TDATA_WIDTH-1)'(0), rsp_flag_ff};

endmodule

// ----- hw/rtl/tdpt_checker.sv -----
// port-level checker of the trial division prime test, with its bind
`include "trial_division_prime_test_assert.svh"

module tdpt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tdpt_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // a stalled result stays and keeps its value
   `TDPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // only the flag bit may be set in a result beat
   `TDPT_ASSERT_SAME(a_rsp_fill, clock, rsp_tvalid, rsp_tdata[tdpt_pkg::RSP_TDATA_WIDTH-1:1] == '0, reset)

   // a taken number keeps the block busy for at least the next cycle
   `TDPT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // reset empties the output register and frees the input
   `TDPT_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
